FILE: hdl/signed_int_to_decimal_ascii_assert.svh
// Assertion macros for the signed integer to decimal ASCII RTL.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define SIDA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define SIDA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/sida_pkg.sv
// Shared constants and types for the signed integer to decimal ASCII block.
`timescale 1ns / 1ps
`default_nettype none

package sida_pkg;

    localparam int DEFAULT_VALUE_BITS = 32;
    localparam int QUEUE_DEPTH        = 2;
    localparam int TAG_BITS           = 8;
    localparam int CHAR_BITS          = 8;

    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;

    // Occupancy flags of the queue between front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

FILE: hdl/sida_front.sv
// Front end: accept an item, split it into sign and magnitude, push it into the queue.
`timescale 1ns / 1ps
`default_nettype none

module sida_front #(
    parameter int VALUE_BITS = sida_pkg::DEFAULT_VALUE_BITS
) (
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic signed [VALUE_BITS-1:0]         value,
    input  wire logic [sida_pkg::TAG_BITS-1:0]        channel,
    input  wire sida_pkg::q_status_t                  q_status,
    output logic                                      push,
    output logic [VALUE_BITS+sida_pkg::TAG_BITS:0]    push_data
);

    logic                  neg;
    logic [VALUE_BITS-1:0] mag;

    // Negate in the full width: the most negative value maps to 2^(VALUE_BITS-1)
    assign neg       = value[VALUE_BITS-1];
    assign mag       = neg ? (VALUE_BITS'(0) - VALUE_BITS'(value)) : VALUE_BITS'(value);

    assign s_tready  = !q_status.full;
    assign push      = s_tvalid && !q_status.full;
    assign push_data = {channel, neg, mag};

endmodule

`default_nettype wire

FILE: hdl/sida_queue.sv
// Small FIFO that decouples the front end from the conversion back end.
`timescale 1ns / 1ps
`default_nettype none

module sida_queue #(
    parameter int WIDTH = sida_pkg::DEFAULT_VALUE_BITS + sida_pkg::TAG_BITS + 1,
    parameter int DEPTH = sida_pkg::QUEUE_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [WIDTH-1:0]  push_data,
    input  wire logic              pop,
    output logic [WIDTH-1:0]       pop_data,
    output sida_pkg::q_status_t    q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign pop_data       = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sida_back.sv
// Back end: digit-by-digit compare-and-subtract decimal conversion and character emission.
`timescale 1ns / 1ps
`default_nettype none

`include "signed_int_to_decimal_ascii_assert.svh"

module sida_back #(
    parameter int VALUE_BITS = sida_pkg::DEFAULT_VALUE_BITS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire sida_pkg::q_status_t                  q_status,
    input  wire logic [VALUE_BITS+sida_pkg::TAG_BITS:0] pop_data,
    output logic                                      pop,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [sida_pkg::CHAR_BITS-1:0]            character,
    output logic [sida_pkg::TAG_BITS-1:0]             out_channel,
    output logic                                      m_tlast
);

    // Decimal digits of 2^(VALUE_BITS-1), the largest magnitude
    localparam int NDIG     = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    // Wide enough for 9 * 10^(NDIG-1)
    localparam int CMP_W    = VALUE_BITS + 4;
    localparam int POS_W    = $clog2(NDIG);
    localparam int TAG_BITS = sida_pkg::TAG_BITS;

    // d * 10^k for every decimal position k and digit d
    typedef logic [NDIG-1:0][9:0][CMP_W-1:0] step_table_t;

    function automatic step_table_t make_steps();
        step_table_t      tbl;
        logic [CMP_W-1:0] pow;
        pow = CMP_W'(1);
        for (int k = 0; k < NDIG; k++) begin
            for (int d = 0; d < 10; d++) begin
                tbl[k][d] = pow * CMP_W'(d);
            end
            pow = pow * CMP_W'(10);
        end
        return tbl;
    endfunction

    localparam step_table_t DIGIT_STEP = make_steps();

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SIGN   = 3'b010,
        ST_DIGITS = 3'b100
    } back_state_t;

    back_state_t           state_reg, state_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic [TAG_BITS-1:0]   chan_reg, chan_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  started_reg, started_next;

    logic                           out_valid_reg, out_valid_next;
    logic [sida_pkg::CHAR_BITS-1:0] out_char_reg, out_char_next;
    logic [TAG_BITS-1:0]            out_chan_reg, out_chan_next;
    logic                           out_last_reg, out_last_next;

    logic                  slot_free;
    logic                  emit;
    logic                  final_pos;
    logic [CMP_W-1:0]      rem_ext;
    logic [9:0][CMP_W-1:0] step_row;
    logic [3:0]            digit;
    logic [CMP_W-1:0]      rem_less;

    assign slot_free = !out_valid_reg || m_tready;
    assign final_pos = (pos_reg == '0);

    // Current decimal digit: the largest d with d * 10^pos not above the remainder
    always_comb begin
        rem_ext  = {4'd0, mag_reg};
        step_row = DIGIT_STEP[pos_reg];
        digit    = 4'd0;
        for (int d = 1; d < 10; d++) begin
            if (rem_ext >= step_row[d]) begin
                digit = 4'(d);
            end
        end
        rem_less = rem_ext - step_row[digit];
    end

    always_comb begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        chan_next      = chan_reg;
        pos_next       = pos_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_chan_next  = out_chan_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        emit           = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (!q_status.empty) begin
                    pop          = 1'b1;
                    mag_next     = pop_data[VALUE_BITS-1:0];
                    neg_next     = pop_data[VALUE_BITS];
                    chan_next    = pop_data[VALUE_BITS+TAG_BITS -: TAG_BITS];
                    pos_next     = POS_W'(NDIG - 1);
                    started_next = 1'b0;
                    state_next   = pop_data[VALUE_BITS] ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN: begin
                if (slot_free) begin
                    emit           = 1'b1;
                    out_valid_next = 1'b1;
                    out_char_next  = sida_pkg::CH_MINUS;
                    out_chan_next  = chan_reg;
                    out_last_next  = 1'b0;
                    state_next     = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (!started_reg && (digit == 4'd0) && !final_pos) begin
                    // drop a leading zero without using the output slot
                    pos_next = pos_reg - 1'b1;
                end else if (slot_free) begin
                    emit           = 1'b1;
                    out_valid_next = 1'b1;
                    out_char_next  = sida_pkg::CH_ZERO + {4'd0, digit};
                    out_chan_next  = chan_reg;
                    out_last_next  = final_pos;
                    mag_next       = rem_less[VALUE_BITS-1:0];
                    pos_next       = pos_reg - 1'b1;
                    started_next   = 1'b1;
                    if (final_pos) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        chan_reg     <= chan_next;
        pos_reg      <= pos_next;
        started_reg  <= started_next;
        out_char_reg <= out_char_next;
        out_chan_reg <= out_chan_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid    = out_valid_reg;
    assign character   = out_char_reg;
    assign out_channel = out_chan_reg;
    assign m_tlast     = out_last_reg;

    `SIDA_ASSERT_IMP(a_pop_in_idle, pop, state_reg == ST_IDLE, "queue popped while busy")
    `SIDA_ASSERT_IMP(a_sign_only_neg, state_reg == ST_SIGN, neg_reg, "sign state on positive item")
    `SIDA_ASSERT_NXT(a_last_ends_item, emit && out_last_next, state_reg == ST_IDLE, "run did not end")
    `SIDA_ASSERT_IMP(a_last_is_digit, out_valid_reg && out_last_reg, out_char_reg != sida_pkg::CH_MINUS, "run ends in minus")

endmodule

`default_nettype wire

FILE: hdl/signed_int_to_decimal_ascii.sv
// Top level: signed integer to decimal ASCII, one character per output item.
// Sequence: per item the back end pops the queue, emits the sign of a negative item and takes
//   one digit step per decimal position; output stalls hold the sign and digit steps.
// Path: the first character passes the queue, the back-end pop and the output register.
// Reset: synchronous active-low aresetn empties the queue, idles the back end and
//   drops any pending output item.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS  = sida_pkg::DEFAULT_VALUE_BITS,
    parameter int QUEUE_DEPTH = sida_pkg::QUEUE_DEPTH
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // Input channel
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [((VALUE_BITS + 7) / 8) * 8-1:0]  s_tdata,  // [VALUE_BITS-1:0] value
    input  wire logic [sida_pkg::TAG_BITS-1:0]          s_tuser,  // [7:0] channel
    // Result channel
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [sida_pkg::CHAR_BITS-1:0]              m_tdata,  // [7:0] character
    output logic [sida_pkg::TAG_BITS-1:0]               m_tuser,  // [7:0] out_channel
    output logic                                        m_tlast   // last character of a number
);

    // Queue entry: {channel, sign, magnitude}
    localparam int ENTRY_W = VALUE_BITS + sida_pkg::TAG_BITS + 1;

    sida_pkg::q_status_t q_status;
    logic                push;
    logic                pop;
    logic [ENTRY_W-1:0]  push_data;
    logic [ENTRY_W-1:0]  pop_data;

    // Front: classify the item and hand it to the queue as soon as a slot is free
    sida_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .value     (s_tdata[VALUE_BITS-1:0]),
        .channel   (s_tuser),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    // Queue: hold classified items while the back end is busy converting
    sida_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_status  (q_status)
    );

    // Back: take one decimal digit per cycle unless the output stalls, most significant first,
    // and emit sign and digits through the output register
    sida_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_status    (q_status),
        .pop_data    (pop_data),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .character   (m_tdata),
        .out_channel (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Testbench for signed_int_to_decimal_ascii: streams integers in and checks every text character.
`timescale 1ns / 1ps

module tb_top;

    localparam int VALUE_BITS = sida_pkg::DEFAULT_VALUE_BITS;
    localparam int DATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;
    localparam int CHAR_BITS  = sida_pkg::CHAR_BITS;
    localparam int TAG_BITS   = sida_pkg::TAG_BITS;
    localparam int RANDOM_ITEMS = 210;
    localparam int SEGMENT_ITEMS = 35;

    // One printed character as it leaves the block
    typedef struct packed {
        logic [CHAR_BITS-1:0] code;
        logic [TAG_BITS-1:0]  chan;
        logic                 last;
    } text_char_t;

    // Holds the characters still owed by the block, oldest first.
    class decimal_text_board;
        text_char_t pending_chars[$];
        int         n_mismatch = 0;

        // Spell one accepted integer as decimal text and queue its characters.
        function void add_number(logic [VALUE_BITS-1:0] value, logic [TAG_BITS-1:0] channel);
            logic [VALUE_BITS-1:0] mag;
            logic [3:0]            digit_q[$];
            logic                  neg;
            text_char_t            ch;
            neg = value[VALUE_BITS-1];
            // Negating in the vector width gives the exact magnitude of the most
            // negative value as an unsigned quantity.
            mag = neg ? (~value + 1'b1) : value;
            ch.chan = channel;
            if (mag == 0) begin
                ch.code = sida_pkg::CH_ZERO;
                ch.last = 1'b1;
                pending_chars.push_back(ch);
                return;
            end
            while (mag != 0) begin
                digit_q.push_front(4'(mag % 10));
                mag = mag / 10;
            end
            if (neg) begin
                ch.code = sida_pkg::CH_MINUS;
                ch.last = 1'b0;
                pending_chars.push_back(ch);
            end
            foreach (digit_q[i]) begin
                ch.code = sida_pkg::CH_ZERO + CHAR_BITS'(digit_q[i]);
                ch.last = (i == digit_q.size() - 1);
                pending_chars.push_back(ch);
            end
        endfunction

        // Compare one accepted character against the oldest one owed.
        function void check_char(text_char_t got);
            text_char_t want;
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected character %h tag %h last %b, none owed",
                         $time, got.code, got.chan, got.last);
                n_mismatch++;
                return;
            end
            want = pending_chars.pop_front();
            if (got !== want) begin
                $display("%0t: expected char %h tag %h last %b, got char %h tag %h last %b",
                         $time, want.code, want.chan, want.last, got.code, got.chan, got.last);
                n_mismatch++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DATA_BITS-1:0] s_tdata;
    logic [TAG_BITS-1:0]  s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [CHAR_BITS-1:0] m_tdata;
    logic [TAG_BITS-1:0]  m_tuser;
    logic                 m_tlast;

    decimal_text_board board = new;
    bit                quiet = 1'b0;   // while set, neither side idles

    signed_int_to_decimal_ascii #(
        .VALUE_BITS (VALUE_BITS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        if (quiet) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Random integer: full range, short numbers, values at and next to powers of ten, or
    // a random bit length; sign chosen at random for all but the full range.
    function automatic logic [VALUE_BITS-1:0] random_number();
        logic [VALUE_BITS-1:0] magnitude;
        int                    pow;
        case ($urandom_range(0, 3))
            0: return VALUE_BITS'($urandom);
            1: magnitude = $urandom_range(0, 999);
            2: begin
                magnitude = 1;
                pow = $urandom_range(0, 9);
                repeat (pow) magnitude = magnitude * 10;
                magnitude = magnitude + $urandom_range(0, 2) - 1;
            end
            default: magnitude = VALUE_BITS'($urandom) >> $urandom_range(0, VALUE_BITS - 1);
        endcase
        return $urandom_range(0, 1) ? -magnitude : magnitude;
    endfunction

    // Present one integer and hold it until the block takes it. Valid stays
    // high across back-to-back items and drops only for a gap.
    task automatic send_number(input logic [VALUE_BITS-1:0] value,
                               input logic [TAG_BITS-1:0] channel);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_BITS'(value);
        s_tuser  <= channel;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Result side backpressure: random stalls between runs of ready.
    initial begin
        int stall;
        m_tready <= 1'b0;
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    end

    // Both handshakes sampled with pre-edge values; the input is noted first.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                board.add_number(s_tdata[VALUE_BITS-1:0], s_tuser);
            if (m_tvalid && m_tready)
                board.check_char('{m_tdata, m_tuser, m_tlast});
        end
    end

    // Directed integers: zero, single digits, powers of ten and their
    // neighbors, both extremes and the value next to the most negative one.
    int dir_values[] = '{0, 0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h8000_0001, 1000000000, -1000000000,
                         999999999, 123456789, -987654321, 1999999999, 5};
    int dir_tags[]   = '{0, 255, 1, 2, 4, 8, 16, 32, 64, 128, 170, 85, 255, 0,
                         15, 240, 51, 204, 7, 99, 165};

    initial begin
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        aresetn  <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn  <= 1'b1;

        foreach (dir_values[i])
            send_number(VALUE_BITS'(dir_values[i]), TAG_BITS'(dir_tags[i]));

        // Random part in segments; the third segment and some others run
        // without any idling on either side.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % SEGMENT_ITEMS == 0)
                quiet = (n / SEGMENT_ITEMS == 2) || ($urandom_range(0, 3) == 0);
            send_number(random_number(), TAG_BITS'($urandom_range(0, 255)));
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        // Drain, then allow for a full conversion to surface any extra output.
        while (board.pending_chars.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (board.n_mismatch == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
